// ===== hdl/mbu_pkg.sv =====
// Shared types and constants for the MIDI byte to USB-MIDI packet converter.
// Used by the byte classifier, the assembler and the top level.
`default_nettype none

package mbu_pkg;

    // System realtime status bytes.
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;
    localparam logic [7:0] RT_SENSE    = 8'hFE;
    localparam logic [7:0] RT_RESET    = 8'hFF;

    // Upper nibble of the system status range.
    localparam logic [3:0] NIB_SYSTEM  = 4'hF;
    // Channel messages that carry a single data byte.
    localparam logic [3:0] NIB_PROGRAM = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT = 4'hD;

    // Code index numbers used on the USB side.
    localparam logic [3:0] CIN_MISC     = 4'h0;
    localparam logic [3:0] CIN_REALTIME = 4'hF;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_REALTIME,
        KIND_SYSTEM,
        KIND_CHANNEL
    } t_kind;

    typedef struct packed {
        logic [3:0] evt_code;
        logic [7:0] msg_byte0;
        logic [7:0] msg_byte1;
        logic [7:0] msg_byte2;
    } t_packet;

    typedef struct packed {
        logic    emit;
        t_packet pkt;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/mbu_byte_if.sv =====
// Request channel carrying one serial MIDI byte per request.
// Stand-alone; no package dependency.
`default_nettype none

interface mbu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbu_packet_if.sv =====
// Request channel carrying one USB-MIDI event packet per request.
// Stand-alone; no package dependency.
`default_nettype none

interface mbu_packet_if;
    logic       valid;
    logic       ready;
    logic [3:0] evt_code;
    logic [7:0] msg_byte0;
    logic [7:0] msg_byte1;
    logic [7:0] msg_byte2;

    modport source (output valid, output evt_code, output msg_byte0,
                    output msg_byte1, output msg_byte2, input ready);
    modport sink   (input valid, input evt_code, input msg_byte0,
                    input msg_byte1, input msg_byte2, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbu_classify.sv =====
// Sorts a received MIDI byte into data, realtime, other system or channel status.
// Depends on mbu_pkg.
`default_nettype none

module mbu_classify (
    input  wire logic [7:0]    i_byte,
    output mbu_pkg::t_kind     o_kind
);

    logic w_realtime;

    always_comb begin
        w_realtime = (i_byte == mbu_pkg::RT_CLOCK)    || (i_byte == mbu_pkg::RT_START) ||
                     (i_byte == mbu_pkg::RT_CONTINUE) || (i_byte == mbu_pkg::RT_STOP)  ||
                     (i_byte == mbu_pkg::RT_SENSE)    || (i_byte == mbu_pkg::RT_RESET);
        priority if (!i_byte[7]) begin
            o_kind = mbu_pkg::KIND_DATA;
        end else if (w_realtime) begin
            o_kind = mbu_pkg::KIND_REALTIME;
        end else if (i_byte[7:4] == mbu_pkg::NIB_SYSTEM) begin
            o_kind = mbu_pkg::KIND_SYSTEM;
        end else begin
            o_kind = mbu_pkg::KIND_CHANNEL;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mbu_assembler.sv =====
// Running-status state and message assembly; decides the packet for one byte.
// Depends on mbu_pkg.
`default_nettype none

module mbu_assembler (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire logic [7:0]     i_byte,
    input  wire mbu_pkg::t_kind i_kind,
    output mbu_pkg::t_result    o_res
);

    // Running status (zero means none), first data byte held, and whether it is held.
    // The status byte of a message under assembly always equals running status.
    logic [7:0] r_running, n_running;
    logic [7:0] r_data1,   n_data1;
    logic       r_have1,   n_have1;
    logic       w_need2;

    assign w_need2 = (r_running[7:4] == mbu_pkg::NIB_PROGRAM) ||
                     (r_running[7:4] == mbu_pkg::NIB_CHAN_AT);

    always_comb begin
        n_running = r_running;
        n_data1   = r_data1;
        n_have1   = r_have1;
        o_res     = '0;
        unique case (i_kind)
            mbu_pkg::KIND_REALTIME: begin
                o_res.emit                = 1'b1;
                o_res.pkt.evt_code        = mbu_pkg::CIN_REALTIME;
                o_res.pkt.msg_byte0       = i_byte;
            end
            mbu_pkg::KIND_SYSTEM: begin
                n_running                 = '0;
                n_have1                   = 1'b0;
                o_res.emit                = 1'b1;
                o_res.pkt.evt_code        = mbu_pkg::CIN_MISC;
                o_res.pkt.msg_byte0       = i_byte;
            end
            mbu_pkg::KIND_CHANNEL: begin
                n_running                 = i_byte;
                n_have1                   = 1'b0;
            end
            mbu_pkg::KIND_DATA: begin
                if (r_running != '0) begin
                    o_res.pkt.evt_code    = r_running[7:4];
                    o_res.pkt.msg_byte0   = r_running;
                    if (r_have1) begin
                        o_res.emit          = 1'b1;
                        o_res.pkt.msg_byte1 = r_data1;
                        o_res.pkt.msg_byte2 = i_byte;
                        n_have1             = 1'b0;
                    end else if (w_need2) begin
                        o_res.emit          = 1'b1;
                        o_res.pkt.msg_byte1 = i_byte;
                    end else begin
                        n_data1             = i_byte;
                        n_have1             = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!i_fire) begin
            o_res.emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_data1   <= '0;
            r_have1   <= 1'b0;
        end else if (i_fire) begin
            r_running <= n_running;
            r_data1   <= n_data1;
            r_have1   <= n_have1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/midi_byte_to_usb_packet.sv =====
// Top level of the serial MIDI byte to USB-MIDI event packet converter.
// Depends on mbu_pkg, mbu_byte_if, mbu_packet_if, mbu_classify and mbu_assembler.
`default_nettype none

// Takes one byte from the serial MIDI line per request and returns at most one
// USB-MIDI event packet per byte, keeping running status. Realtime bytes (F8, FA,
// FB, FC, FE, FF) go out at once with code index 15 and leave a message under
// assembly untouched. Other system bytes clear running status and go out at once
// with code index 0. Channel status bytes set running status; a channel message
// goes out when its two or three bytes are complete, with unused bytes zero, and
// later data bytes reuse the running status. Data bytes with no running status
// are dropped. A byte is registered on acceptance, decided by a short
// classify-and-assemble step once the packet register can take the result, and
// its packet lands in the output register; one byte can be accepted every cycle
// as long as the packet side keeps taking requests. The byte register and the
// packet register are separate, so one new byte is still accepted while a
// finished packet waits at the output.

module midi_byte_to_usb_packet (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    mbu_byte_if.sink            i_rx,
    mbu_packet_if.source        o_pkt
);

    // Input register holding the byte under decision.
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    // Output register holding the finished packet.
    logic                 r_out_valid;
    mbu_pkg::t_packet     r_out_pkt;

    logic                 w_out_free;
    logic                 w_fire;
    mbu_pkg::t_kind       w_kind;
    mbu_pkg::t_result     w_res;

    // The held byte is processed whenever the packet register can take its result;
    // bytes that produce nothing also retire then.
    assign w_out_free = !r_out_valid || o_pkt.ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mbu_classify u_classify (
        .i_byte (r_in_byte),
        .o_kind (w_kind)
    );

    mbu_assembler u_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_kind  (w_kind),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res.emit) begin
            r_out_pkt <= w_res.pkt;
        end
    end

    assign o_pkt.valid      = r_out_valid;
    assign o_pkt.evt_code   = r_out_pkt.evt_code;
    assign o_pkt.msg_byte0  = r_out_pkt.msg_byte0;
    assign o_pkt.msg_byte1  = r_out_pkt.msg_byte1;
    assign o_pkt.msg_byte2  = r_out_pkt.msg_byte2;

`ifndef SYNTHESIS
    // A byte waiting on a stalled packet side must not be lost.
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost while packet side stalled");

    // A realtime packet carries a realtime status byte and no data.
    a_realtime_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pkt.valid && o_pkt.evt_code == mbu_pkg::CIN_REALTIME) |->
        (o_pkt.msg_byte0[7:3] == 5'h1F && o_pkt.msg_byte1 == '0 && o_pkt.msg_byte2 == '0))
        else $error("malformed realtime packet");

    // Back-pressure on the byte side only appears while a byte is held.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_in_valid && r_out_valid))
        else $error("byte side stalled without cause");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_midi_byte_to_usb_packet.sv =====
// Self-checking testbench for midi_byte_to_usb_packet: MIDI bytes in, USB-MIDI packets out.
// Depends on mbu_pkg, mbu_byte_if, mbu_packet_if and the top level of the converter.
`timescale 1ns / 1ps

module tb_midi_byte_to_usb_packet;

    // Length of the one long output hold-off, counted in cycles by the packet receiver.
    localparam int LONG_HOLD_CYCLES = 80;
    // Cycles to let pass after the last expected packet.
    localparam int DRAIN_CYCLES     = 8;
    // Bound on the final wait for outstanding packets.
    localparam int DRAIN_LIMIT      = 4000;

    // Running-status packet predictor plus the queue of packets still awaited.
    class usb_packet_scoreboard;
        logic [7:0]        run_status;
        logic [7:0]        msg_bytes [3];
        int unsigned       fill;
        mbu_pkg::t_packet  awaited [$];
        int unsigned       failures;

        function new();
            run_status = 8'h00;
            msg_bytes  = '{8'h00, 8'h00, 8'h00};
            fill       = 0;
            failures   = 0;
        endfunction

        // Advances the predicted state by one accepted byte and queues its packet, if any.
        function void note_byte(input logic [7:0] b);
            logic [3:0]       hi;
            logic [3:0]       cin;
            int               need;
            mbu_pkg::t_packet p;
            if (b[7]) begin
                if (b[7:4] == mbu_pkg::NIB_SYSTEM) begin
                    if (b == mbu_pkg::RT_CLOCK || b == mbu_pkg::RT_START ||
                        b == mbu_pkg::RT_CONTINUE || b == mbu_pkg::RT_STOP ||
                        b == mbu_pkg::RT_SENSE || b == mbu_pkg::RT_RESET) begin
                        // Realtime passes straight through; the partial message stays.
                        p = '{evt_code: mbu_pkg::CIN_REALTIME, msg_byte0: b,
                              msg_byte1: 8'h00, msg_byte2: 8'h00};
                        awaited.push_back(p);
                        return;
                    end
                    run_status = 8'h00;
                end else begin
                    run_status = b;
                end
                msg_bytes[0] = b;
                fill = 1;
            end else begin
                if (run_status == 8'h00) begin
                    return;
                end
                if (fill == 0) begin
                    msg_bytes[0] = run_status;
                    fill = 1;
                end
                if (fill < 3) begin
                    msg_bytes[fill] = b;
                    fill++;
                end
            end
            hi = msg_bytes[0][7:4];
            case (hi)
                mbu_pkg::NIB_PROGRAM, mbu_pkg::NIB_CHAN_AT: begin
                    need = 2;
                    cin  = hi;
                end
                mbu_pkg::NIB_SYSTEM: begin
                    need = 0;
                    cin  = mbu_pkg::CIN_MISC;
                end
                default: begin
                    need = 3;
                    cin  = hi;
                end
            endcase
            if (fill >= need) begin
                p = '{evt_code: cin, msg_byte0: msg_bytes[0],
                      msg_byte1: (need >= 2) ? msg_bytes[1] : 8'h00,
                      msg_byte2: (need >= 3) ? msg_bytes[2] : 8'h00};
                awaited.push_back(p);
                fill = 0;
            end
        endfunction

        function void check_packet(input mbu_pkg::t_packet got);
            mbu_pkg::t_packet want;
            if (awaited.size() == 0) begin
                failures++;
                $display("%0t: unexpected packet, expected none, actual ci=%h b0=%h b1=%h b2=%h",
                         $time, got.evt_code, got.msg_byte0, got.msg_byte1, got.msg_byte2);
                return;
            end
            want = awaited.pop_front();
            if (got.evt_code != want.evt_code || got.msg_byte0 != want.msg_byte0 ||
                got.msg_byte1 != want.msg_byte1 || got.msg_byte2 != want.msg_byte2) begin
                failures++;
                $display("%0t: packet mismatch, expected ci=%h b0=%h b1=%h b2=%h,",
                         $time, want.evt_code, want.msg_byte0, want.msg_byte1,
                         want.msg_byte2);
                $display("    actual ci=%h b0=%h b1=%h b2=%h",
                         got.evt_code, got.msg_byte0, got.msg_byte1, got.msg_byte2);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag_leftover();
            if (awaited.size() != 0) begin
                failures++;
                $display("%0t: %0d packets never arrived, oldest ci=%h b0=%h", $time,
                         awaited.size(), awaited[0].evt_code, awaited[0].msg_byte0);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbu_byte_if   rx_if ();
    mbu_packet_if pkt_if ();

    midi_byte_to_usb_packet u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_pkt   (pkt_if)
    );

    usb_packet_scoreboard sb = new();

    // Control flags for the sender and the receiver and a count of sent bytes; plain variables, not block inputs.
    bit          sender_gaps;
    bit          receiver_stalls;
    bit          calm;
    bit          long_hold_req;
    int unsigned bytes_sent;

    logic [7:0] rt_codes  [6]  = '{mbu_pkg::RT_CLOCK, mbu_pkg::RT_START,
                                   mbu_pkg::RT_CONTINUE, mbu_pkg::RT_STOP,
                                   mbu_pkg::RT_SENSE, mbu_pkg::RT_RESET};
    // System status bytes that are not realtime: SysEx start and end, common messages,
    // and the four undefined codes.
    logic [7:0] sys_codes [10] = '{8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
                                   8'hF9, 8'hFD};

    // Directed opening: data with no running status, every channel message kind, running
    // status reuse, realtime inside a message, a status byte that cuts a message short,
    // SysEx data that must be dropped, and all realtime codes.
    logic [7:0] directed_bytes [28] = '{
        8'h00, 8'h7F,                      // dropped, nothing to attach them to
        8'h90, 8'h3C, 8'h7F, 8'h40, 8'h00, // note on, then a second note by running status
        8'hC5, 8'hF8, 8'h7F, 8'h01,        // program change, clock inside it, reuse
        8'hD0, 8'h55,                      // channel pressure
        8'hEF, 8'h00, 8'hFA, 8'h7F,        // pitch bend with a start byte in the middle
        8'hB1, 8'h07,                      // control change left unfinished ...
        8'hF0, 8'h11, 8'hF7,               // ... by SysEx, whose data is dropped
        8'hFB, 8'hFC, 8'hFE, 8'hFF,        // the remaining realtime codes
        8'hA2, 8'h80                       // aftertouch cut short by note off
    };

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Every accepted byte advances the predictor; every accepted packet is checked
    // against the oldest prediction. Both monitors sample the values that stood just
    // before the rising edge, because all drivers use nonblocking assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            sb.note_byte(rx_if.rx_byte);
        end
    end

    always @(posedge i_clk) begin
        mbu_pkg::t_packet got;
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            got = '{evt_code: pkt_if.evt_code, msg_byte0: pkt_if.msg_byte0,
                    msg_byte1: pkt_if.msg_byte1, msg_byte2: pkt_if.msg_byte2};
            sb.check_packet(got);
        end
    end

    // Packet receiver. Ready drops for random bursts while stalls are on, the stall
    // mode flips at random so that clean stretches occur, and once on request it
    // holds ready low through the long hold-off so that the block backs up into its
    // byte input. In the closing part of the run it always takes packets.
    initial begin
        int n;
        pkt_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                pkt_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && receiver_stalls && $urandom_range(0, 5) == 0) begin
                pkt_if.ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge i_clk);
            end else begin
                pkt_if.ready <= 1'b1;
                @(posedge i_clk);
                if ($urandom_range(0, 47) == 0) begin
                    receiver_stalls = !receiver_stalls;
                end
            end
        end
    end

    // Offers one byte and returns at the edge where the request is taken. A random
    // idle burst may come first; valid is only lowered on the way into such a burst,
    // so back-to-back bytes keep valid high with a single assignment per edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (sender_gaps && !calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 18);
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    // Random byte stream, mostly well-formed MIDI with random content: channel messages
    // repeated under running status, realtime bytes slipped in between, SysEx blocks,
    // system common bytes, and a share of broken messages and raw noise.
    task automatic send_midi_stream(input int unsigned n_bytes);
        int unsigned stop_at;
        int          kind;
        int          reps;
        int          n_data;
        bit          cut;
        logic [7:0]  st;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                sender_gaps = !sender_gaps;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                st     = 8'($urandom_range(8'h80, 8'hEF));
                n_data = (st[7:4] == mbu_pkg::NIB_PROGRAM ||
                          st[7:4] == mbu_pkg::NIB_CHAN_AT) ? 1 : 2;
                reps   = $urandom_range(1, 4);
                cut    = 1'b0;
                // Now and then the status is left out, so the data lean on whatever
                // running status is left over, or get dropped.
                if ($urandom_range(0, 7) != 0) begin
                    send_byte(st);
                end
                for (int r = 0; r < reps && !cut; r++) begin
                    for (int d = 0; d < n_data && !cut; d++) begin
                        if ($urandom_range(0, 9) == 0) begin
                            send_byte(rt_codes[$urandom_range(0, 5)]);
                        end
                        if ($urandom_range(0, 24) == 0) begin
                            cut = 1'b1;
                        end else begin
                            send_byte(8'($urandom_range(0, 127)));
                        end
                    end
                end
            end else if (kind == 6) begin
                send_byte(8'hF0);
                reps = $urandom_range(0, 4);
                repeat (reps) send_byte(8'($urandom_range(0, 127)));
                send_byte(8'hF7);
            end else if (kind == 7) begin
                send_byte(sys_codes[$urandom_range(0, 9)]);
            end else if (kind == 8) begin
                send_byte(rt_codes[$urandom_range(0, 5)]);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Main sequence: reset, directed bytes, random traffic with idling on both sides,
    // a burst against a long output hold-off, a full pause until every packet is out,
    // more random traffic, and a closing stretch with no idling at all.
    initial begin
        int n;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        calm            = 1'b0;
        long_hold_req   = 1'b0;
        bytes_sent      = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end

        send_midi_stream(250);

        // The receiver holds off while bytes keep coming without gaps, so the block
        // fills and has to refuse requests on its input.
        sender_gaps   = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end

        // The sender waits until every predicted packet has come out.
        rx_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        sender_gaps = 1'b1;

        send_midi_stream(250);

        calm = 1'b1;
        send_midi_stream(90);
        rx_if.valid <= 1'b0;

        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (sb.pending() != 0 && n < DRAIN_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flag_leftover();

        if (sb.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 650 bytes.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mbu_pkg.sv
hdl/mbu_byte_if.sv
hdl/mbu_packet_if.sv
hdl/mbu_classify.sv
hdl/mbu_assembler.sv
hdl/midi_byte_to_usb_packet.sv
tb/tb_midi_byte_to_usb_packet.sv
